[hdl/cfm_pkg.sv]
// Shared constants, types and helper functions of the cylindrical frame matrix.
package cfm_pkg;

    localparam int ONE_Q30   = 1 << 30;
    localparam int CFG_IDX_W = 3;
    localparam int U_W       = 31;
    localparam int UMAG_W    = 31;
    localparam int N2_W      = 62;
    localparam int ROOT_W    = 31;
    localparam int REM_W     = 33;
    localparam int NUM_W     = 61;
    localparam int DR_W      = 32;
    localparam int STEPS     = 31;
    localparam int OUT_W     = 32;

    localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;
    localparam logic signed [31:0] Q30_NEG = -32'sh4000_0000;
    localparam logic signed [32:0] Q16_ONE = 33'sh0_0001_0000;

    typedef logic signed [31:0] t_q30;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE  = 3'd0,
        REG_AP_X  = 3'd1,
        REG_AP_Y  = 3'd2,
        REG_AP_Z  = 3'd3,
        REG_DIR_X = 3'd4,
        REG_DIR_Y = 3'd5,
        REG_DIR_Z = 3'd6
    } t_cfg_idx;

    function automatic t_q30 sat_dir(input logic [31:0] v);
        t_q30 x;
        x = signed'(v);
        if (x > Q30_ONE) begin
            return Q30_ONE;
        end
        if (x < Q30_NEG) begin
            return Q30_NEG;
        end
        return x;
    endfunction

endpackage

[hdl/cfm_sqrt_cell.sv]
// One cell of the square root chain: settles one root bit per stage.
module cfm_sqrt_cell #(
    parameter int PW = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [cfm_pkg::N2_W-1:0]   i_n,
    input  logic [cfm_pkg::REM_W-1:0]  i_rem,
    input  logic [cfm_pkg::ROOT_W-1:0] i_root,
    input  logic [PW-1:0]              i_pay,
    output logic                       o_valid,
    output logic [cfm_pkg::N2_W-1:0]   o_n,
    output logic [cfm_pkg::REM_W-1:0]  o_rem,
    output logic [cfm_pkg::ROOT_W-1:0] o_root,
    output logic [PW-1:0]              o_pay
);
    import cfm_pkg::*;

    logic [REM_W+1:0] w_cur;
    logic [REM_W+1:0] w_trial;
    logic [REM_W+1:0] w_diff;
    logic             w_ge;

    logic              r_valid;
    logic [N2_W-1:0]   r_n;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [PW-1:0]     r_pay;

    assign w_cur   = {i_rem, i_n[N2_W-1 -: 2]};
    assign w_trial = {2'b00, i_root, 2'b01};
    assign w_diff  = w_cur - w_trial;
    assign w_ge    = (w_cur >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n    <= {i_n[N2_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[REM_W-1:0] : w_cur[REM_W-1:0];
            r_root <= {i_root[ROOT_W-2:0], w_ge};
            r_pay  <= i_pay;
        end
    end

    assign o_valid = r_valid;
    assign o_n     = r_n;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_pay   = r_pay;

endmodule

[hdl/cfm_div_cell.sv]
// One cell of the divider chain: settles one quotient bit of three lanes per stage.
module cfm_div_cell #(
    parameter int PW = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [cfm_pkg::DR_W-1:0]   i_rem [3],
    input  logic [cfm_pkg::STEPS-1:0]  i_lo [3],
    input  logic [cfm_pkg::ROOT_W-1:0] i_div,
    input  logic [PW-1:0]              i_pay,
    output logic                       o_valid,
    output logic [cfm_pkg::DR_W-1:0]   o_rem [3],
    output logic [cfm_pkg::STEPS-1:0]  o_lo [3],
    output logic [cfm_pkg::ROOT_W-1:0] o_div,
    output logic [PW-1:0]              o_pay
);
    import cfm_pkg::*;

    logic [DR_W-1:0]  w_t [3];
    logic [DR_W-1:0]  w_d [3];
    logic             w_ge [3];

    logic              r_valid;
    logic [DR_W-1:0]   r_rem [3];
    logic [STEPS-1:0]  r_lo [3];
    logic [ROOT_W-1:0] r_div;
    logic [PW-1:0]     r_pay;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_t[l]  = {i_rem[l][DR_W-2:0], i_lo[l][STEPS-1]};
            w_ge[l] = (w_t[l] >= {1'b0, i_div});
            w_d[l]  = w_t[l] - {1'b0, i_div};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_rem[l] <= w_ge[l] ? w_d[l] : w_t[l];
                r_lo[l]  <= {i_lo[l][STEPS-2:0], w_ge[l]};
            end
            r_div <= i_div;
            r_pay <= i_pay;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_lo    = r_lo;
    assign o_div   = r_div;
    assign o_pay   = r_pay;

endmodule

[hdl/cfm_unitize.sv]
// Pipelined vector normalizer: block scaling, sum of squares, root and divider chains.
module cfm_unitize #(
    parameter int IW = 34,
    parameter int SW = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic signed [IW-1:0]   i_x [3],
    input  logic [SW-1:0]          i_side,
    output logic                   o_valid,
    output logic signed [cfm_pkg::OUT_W-1:0] o_y [3],
    output logic                   o_zero,
    output logic [SW-1:0]          o_side
);
    import cfm_pkg::*;

    localparam int MW  = $clog2(IW);
    localparam int PW1 = 3 * UMAG_W + 4 + SW;
    localparam int PW2 = 4 + SW;

    logic [IW-1:0]         w_mag [3];
    logic [IW-1:0]         w_or;
    logic [MW-1:0]         w_msb;
    logic signed [IW-1:0]  w_sh [3];
    logic [U_W-1:0]        w_um [3];

    logic                  r_a_valid;
    logic signed [IW-1:0]  r_a_x [3];
    logic [MW-1:0]         r_a_msb;
    logic                  r_a_zero;
    logic [SW-1:0]         r_a_side;

    logic                  r_b_valid;
    logic signed [U_W-1:0] r_b_u [3];
    logic                  r_b_zero;
    logic [SW-1:0]         r_b_side;

    logic                  r_c_valid;
    logic [2*UMAG_W-1:0]   r_c_sq [3];
    logic [UMAG_W-1:0]     r_c_mag [3];
    logic [2:0]            r_c_sgn;
    logic                  r_c_zero;
    logic [SW-1:0]         r_c_side;

    logic                  r_d_valid;
    logic [N2_W-1:0]       r_d_n2;
    logic [PW1-1:0]        r_d_pay;

    logic                  sq_v [0:STEPS];
    logic [N2_W-1:0]       sq_n [0:STEPS];
    logic [REM_W-1:0]      sq_r [0:STEPS];
    logic [ROOT_W-1:0]     sq_q [0:STEPS];
    logic [PW1-1:0]        sq_p [0:STEPS];

    logic [NUM_W-1:0]      w_num [3];
    logic [UMAG_W-1:0]     w_emag [3];

    logic                  dv_v [0:STEPS];
    logic [DR_W-1:0]       dv_r [0:STEPS][3];
    logic [STEPS-1:0]      dv_l [0:STEPS][3];
    logic [ROOT_W-1:0]     dv_s [0:STEPS];
    logic [PW2-1:0]        dv_p [0:STEPS];

    logic                  r_e_valid;
    logic [DR_W-1:0]       r_e_rem [3];
    logic [STEPS-1:0]      r_e_lo [3];
    logic [ROOT_W-1:0]     r_e_s;
    logic [PW2-1:0]        r_e_pay;

    logic [STEPS-1:0]      w_qc [3];
    logic [PW2-1:0]        w_fp;

    logic                  r_f_valid;
    logic signed [OUT_W-1:0] r_f_y [3];
    logic                  r_f_zero;
    logic [SW-1:0]         r_f_side;

    always_comb begin
        w_or = '0;
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = i_x[i][IW-1] ? (~i_x[i] + 1'b1) : i_x[i];
            w_or     = w_or | w_mag[i];
        end
        w_msb = '0;
        for (int k = 0; k < IW; k++) begin
            if (w_or[k]) begin
                w_msb = MW'(k);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_a_msb >= MW'(U_W - 1)) begin
                w_sh[i] = r_a_x[i] >>> (r_a_msb - MW'(U_W - 2));
            end else begin
                w_sh[i] = r_a_x[i] <<< (MW'(U_W - 2) - r_a_msb);
            end
            w_um[i] = r_b_u[i][U_W-1] ? (~r_b_u[i] + 1'b1) : r_b_u[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= sq_v[STEPS];
            r_f_valid <= dv_v[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_x    <= i_x;
            r_a_msb  <= w_msb;
            r_a_zero <= (w_or == '0);
            r_a_side <= i_side;
            for (int i = 0; i < 3; i++) begin
                r_b_u[i] <= w_sh[i][U_W-1:0];
            end
            r_b_zero <= r_a_zero;
            r_b_side <= r_a_side;
            for (int i = 0; i < 3; i++) begin
                r_c_mag[i] <= w_um[i][UMAG_W-1:0];
                r_c_sq[i]  <= w_um[i][UMAG_W-1:0] * w_um[i][UMAG_W-1:0];
                r_c_sgn[i] <= r_b_u[i][U_W-1];
            end
            r_c_zero <= r_b_zero;
            r_c_side <= r_b_side;
            r_d_n2   <= N2_W'(r_c_sq[0]) + N2_W'(r_c_sq[1]) + N2_W'(r_c_sq[2]);
            r_d_pay  <= {r_c_mag[2], r_c_mag[1], r_c_mag[0], r_c_sgn, r_c_zero, r_c_side};
        end
    end

    assign sq_v[0] = r_d_valid;
    assign sq_n[0] = r_d_n2;
    assign sq_r[0] = '0;
    assign sq_q[0] = '0;
    assign sq_p[0] = r_d_pay;

    for (genvar k = 0; k < STEPS; k++) begin : g_sqrt
        cfm_sqrt_cell #(.PW(PW1)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (sq_v[k]),
            .i_n     (sq_n[k]),
            .i_rem   (sq_r[k]),
            .i_root  (sq_q[k]),
            .i_pay   (sq_p[k]),
            .o_valid (sq_v[k+1]),
            .o_n     (sq_n[k+1]),
            .o_rem   (sq_r[k+1]),
            .o_root  (sq_q[k+1]),
            .o_pay   (sq_p[k+1])
        );
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_emag[i] = sq_p[STEPS][PW2 + i*UMAG_W +: UMAG_W];
            w_num[i]  = {w_emag[i], {(NUM_W - UMAG_W){1'b0}}}
                      + NUM_W'(sq_q[STEPS][ROOT_W-1:1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_e_rem[i] <= DR_W'(w_num[i][NUM_W-1:STEPS]);
                r_e_lo[i]  <= w_num[i][STEPS-1:0];
            end
            r_e_s   <= sq_q[STEPS];
            r_e_pay <= sq_p[STEPS][PW2-1:0];
        end
    end

    assign dv_v[0] = r_e_valid;
    assign dv_r[0] = r_e_rem;
    assign dv_l[0] = r_e_lo;
    assign dv_s[0] = r_e_s;
    assign dv_p[0] = r_e_pay;

    for (genvar k = 0; k < STEPS; k++) begin : g_div
        cfm_div_cell #(.PW(PW2)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (dv_v[k]),
            .i_rem   (dv_r[k]),
            .i_lo    (dv_l[k]),
            .i_div   (dv_s[k]),
            .i_pay   (dv_p[k]),
            .o_valid (dv_v[k+1]),
            .o_rem   (dv_r[k+1]),
            .o_lo    (dv_l[k+1]),
            .o_div   (dv_s[k+1]),
            .o_pay   (dv_p[k+1])
        );
    end

    assign w_fp = dv_p[STEPS];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (dv_l[STEPS][i] > STEPS'(ONE_Q30)) begin
                w_qc[i] = STEPS'(ONE_Q30);
            end else begin
                w_qc[i] = dv_l[STEPS][i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (w_fp[SW]) begin
                    r_f_y[i] <= '0;
                end else if (w_fp[SW+1+i]) begin
                    r_f_y[i] <= -signed'({1'b0, w_qc[i]});
                end else begin
                    r_f_y[i] <= signed'({1'b0, w_qc[i]});
                end
            end
            r_f_zero <= w_fp[SW];
            r_f_side <= w_fp[SW-1:0];
        end
    end

    assign o_valid = r_f_valid;
    assign o_y     = r_f_y;
    assign o_zero  = r_f_zero;
    assign o_side  = r_f_side;

endmodule

[hdl/cylindrical_frame_matrix.sv]
// Top level of the cylindrical frame matrix: point in, orthonormal 3x3 frame out.
//
// The slave stream takes one point per word (x, y, z in Q16.16) and the master
// stream returns one frame per word: nine Q2.30 matrix entries in tdata and the
// degenerate flag in tuser. The configuration port writes the mode, the axis
// point and the axis direction; the user must write it only while no word is
// in flight, which the block itself does not enforce. The datapath is a
// pipeline that takes a new point every cycle unless the output stalls. Most
// of it is in the two normalizers: 31 root cells, then 31 divider cells each.
// Throughput is one word per cycle while the receiver takes every word.
// When the receiver stalls, the output register holds its word and the whole
// pipeline freezes, so the slave side drops tready in the same cycle.
// Reset clears all valid flags and loads the registers with identity mode,
// axis point at the origin and axis direction along z.
module cylindrical_frame_matrix (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [95:0]                   i_s_tdata,   // point_x, point_y, point_z
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [287:0]                  o_m_tdata,   // m_r0_c0 .. m_r2_c0, m_r0_c1 ..
                                                       // m_r2_c1, m_r0_c2 .. m_r2_c2
    output logic [0:0]                    o_m_tuser,   // degenerate
    input  logic                          i_cfg_we,
    input  logic [cfm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                   i_cfg_data
);
    import cfm_pkg::*;

    localparam int SW2 = 2 + 3 * OUT_W;

    logic        w_en;
    logic        r_mode;
    logic [31:0] r_ap [3];
    logic [31:0] r_dir [3];
    t_q30        w_d [3];

    logic                 r0_valid;
    logic signed [31:0]   r0_p [3];
    logic                 r1_valid;
    logic signed [32:0]   r1_e [3];
    logic                 r1_mode;
    logic signed [32:0]   w_e [3];
    logic [32:0]          w_emag [3];
    logic [32:0]          w_eor;
    logic [5:0]           w_emsb;
    logic                 r2_valid;
    logic signed [32:0]   r2_e [3];
    logic [5:0]           r2_msb;
    logic                 r2_mode;
    logic signed [32:0]   w_esh [3];
    logic                 r3_valid;
    logic signed [U_W-1:0] r3_w [3];
    logic                 r3_mode;
    logic                 r4_valid;
    logic signed [62:0]   r4_pr [3];
    logic signed [U_W-1:0] r4_w [3];
    logic                 r4_mode;
    logic signed [63:0]   w_dot;
    logic signed [63:0]   w_a;
    logic                 r5_valid;
    logic signed [33:0]   r5_a;
    logic signed [U_W-1:0] r5_w [3];
    logic                 r5_mode;
    logic                 r6_valid;
    logic signed [65:0]   r6_ad [3];
    logic signed [U_W-1:0] r6_w [3];
    logic                 r6_mode;
    logic signed [65:0]   w_t [3];
    logic                 r7_valid;
    logic signed [33:0]   r7_r [3];
    logic                 r7_mode;

    logic                    u1_valid;
    logic signed [OUT_W-1:0] u1_y [3];
    logic                    u1_zero;
    logic [0:0]              u1_side;

    logic                 x1_valid;
    logic signed [63:0]   x1_p [6];
    logic [SW2-1:0]       x1_side;
    logic                 x2_valid;
    logic signed [63:0]   x2_c [3];
    logic [SW2-1:0]       x2_side;

    logic                    u2_valid;
    logic signed [OUT_W-1:0] u2_y [3];
    logic                    u2_zero;
    logic [SW2-1:0]          u2_side;
    logic signed [OUT_W-1:0] w_lx [3];

    logic         r_o_valid;
    logic [287:0] r_o_data;
    logic         r_o_degen;

    assign w_en       = !r_o_valid || i_m_tready;
    assign o_s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_ap[0]  <= '0;
            r_ap[1]  <= '0;
            r_ap[2]  <= '0;
            r_dir[0] <= '0;
            r_dir[1] <= '0;
            r_dir[2] <= Q30_ONE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_MODE:  r_mode   <= i_cfg_data[0];
                REG_AP_X:  r_ap[0]  <= i_cfg_data;
                REG_AP_Y:  r_ap[1]  <= i_cfg_data;
                REG_AP_Z:  r_ap[2]  <= i_cfg_data;
                REG_DIR_X: r_dir[0] <= i_cfg_data;
                REG_DIR_Y: r_dir[1] <= i_cfg_data;
                REG_DIR_Z: r_dir[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d[i] = sat_dir(r_dir[i]);
            w_e[i] = 33'(r0_p[i]) - 33'(signed'(r_ap[i]));
        end
        if (w_e[0] == '0 && w_e[1] == '0 && w_e[2] == '0) begin
            w_e[0] = Q16_ONE;
        end
    end

    always_comb begin
        w_eor = '0;
        for (int i = 0; i < 3; i++) begin
            w_emag[i] = r1_e[i][32] ? (~r1_e[i] + 1'b1) : r1_e[i];
            w_eor     = w_eor | w_emag[i];
        end
        w_emsb = '0;
        for (int k = 0; k < 33; k++) begin
            if (w_eor[k]) begin
                w_emsb = 6'(k);
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (r2_msb >= 6'(U_W - 1)) begin
                w_esh[i] = r2_e[i] >>> (r2_msb - 6'(U_W - 2));
            end else begin
                w_esh[i] = r2_e[i] <<< (6'(U_W - 2) - r2_msb);
            end
        end
    end

    assign w_dot = 64'(r4_pr[0]) + 64'(r4_pr[1]) + 64'(r4_pr[2]);
    assign w_a   = (w_dot + 64'sd536870912) >>> 30;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_t[i] = (r6_ad[i] + 66'sd536870912) >>> 30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
            x1_valid <= 1'b0;
            x2_valid <= 1'b0;
        end else if (w_en) begin
            r0_valid <= i_s_tvalid;
            r1_valid <= r0_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
            r7_valid <= r6_valid;
            x1_valid <= u1_valid;
            x2_valid <= x1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_p[0] <= signed'(i_s_tdata[31:0]);
            r0_p[1] <= signed'(i_s_tdata[63:32]);
            r0_p[2] <= signed'(i_s_tdata[95:64]);
            r1_e    <= w_e;
            r1_mode <= r_mode;
            r2_e    <= r1_e;
            r2_msb  <= w_emsb;
            r2_mode <= r1_mode;
            for (int i = 0; i < 3; i++) begin
                r3_w[i]  <= w_esh[i][U_W-1:0];
                r4_pr[i] <= r3_w[i] * w_d[i];
                r6_ad[i] <= r5_a * w_d[i];
                r7_r[i]  <= 34'(r6_w[i]) - w_t[i][33:0];
            end
            r3_mode <= r2_mode;
            r4_w    <= r3_w;
            r4_mode <= r3_mode;
            r5_a    <= w_a[33:0];
            r5_w    <= r4_w;
            r5_mode <= r4_mode;
            r6_w    <= r5_w;
            r6_mode <= r5_mode;
            r7_mode <= r6_mode;
        end
    end

    cfm_unitize #(.IW(34), .SW(1)) u_radial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r7_valid),
        .i_x     (r7_r),
        .i_side  (r7_mode),
        .o_valid (u1_valid),
        .o_y     (u1_y),
        .o_zero  (u1_zero),
        .o_side  (u1_side)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            x1_p[0] <= u1_y[1] * w_d[2];
            x1_p[1] <= u1_y[2] * w_d[1];
            x1_p[2] <= u1_y[2] * w_d[0];
            x1_p[3] <= u1_y[0] * w_d[2];
            x1_p[4] <= u1_y[0] * w_d[1];
            x1_p[5] <= u1_y[1] * w_d[0];
            x1_side <= {u1_side[0], u1_zero, u1_y[2], u1_y[1], u1_y[0]};
            x2_c[0] <= x1_p[0] - x1_p[1];
            x2_c[1] <= x1_p[2] - x1_p[3];
            x2_c[2] <= x1_p[4] - x1_p[5];
            x2_side <= x1_side;
        end
    end

    cfm_unitize #(.IW(64), .SW(SW2)) u_tangent (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (x2_valid),
        .i_x     (x2_c),
        .i_side  (x2_side),
        .o_valid (u2_valid),
        .o_y     (u2_y),
        .o_zero  (u2_zero),
        .o_side  (u2_side)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_lx[i] = signed'(u2_side[i*OUT_W +: OUT_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= u2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (!u2_side[SW2-1]) begin
                r_o_data  <= {Q30_ONE, 96'd0, Q30_ONE, 96'd0, Q30_ONE};
                r_o_degen <= 1'b0;
            end else if (u2_side[SW2-2]) begin
                r_o_data  <= '0;
                r_o_degen <= 1'b1;
            end else begin
                r_o_data  <= {w_d[2], w_d[1], w_d[0], u2_y[2], u2_y[1], u2_y[0],
                              w_lx[2], w_lx[1], w_lx[0]};
                r_o_degen <= 1'b0;
            end
        end
    end

    assign o_m_tvalid   = r_o_valid;
    assign o_m_tdata    = r_o_data;
    assign o_m_tuser[0] = r_o_degen;

endmodule

[hdl/cfm_checker.sv]
// Port-level checker of the cylindrical frame matrix and its bind statement.
module cfm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic [95:0]                   i_s_tdata,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [287:0]                  o_m_tdata,
    input logic [0:0]                    o_m_tuser,
    input logic                          i_cfg_we,
    input logic [cfm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input logic [31:0]                   i_cfg_data
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output word dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("output word changed while stalled");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == '0)
        else $error("degenerate frame is not all zero");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked while output is empty");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule

bind cylindrical_frame_matrix cfm_checker u_cfm_checker (.*);
